// ===== rtl/tournament_branch_predictor_top_macros.svh =====
// assertion macros shared by the predictor rtl
`ifndef TOURNAMENT_BRANCH_PREDICTOR_TOP_MACROS_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define TBP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define TBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tbp_pkg.sv =====
// shared types, constants and counter helpers of the branch predictor
package tbp_pkg;

  // table geometry
  localparam int GHB = 14;  // global history bits
  localparam int LHB = 14;  // local history bits
  localparam int LIB = 11;  // local history table index bits
  localparam int CIB = 12;  // chooser index bits

  localparam int MAX_GL   = (GHB > LHB) ? GHB : LHB;
  localparam int MAX_LC   = (LIB > CIB) ? LIB : CIB;
  localparam int CLR_BITS = (MAX_GL > MAX_LC) ? MAX_GL : MAX_LC;

  typedef logic [1:0] ctr_t;

  // 2-bit counter clear values and bounds
  localparam ctr_t CTR_WEAK_NT  = 2'd1;
  localparam ctr_t CTR_STRONG_T = 2'd3;
  localparam ctr_t CTR_MAX      = 2'd3;
  localparam ctr_t CTR_MIN      = 2'd0;

  // mode register codes
  localparam logic [1:0] MODE_STATIC = 2'd0;
  localparam logic [1:0] MODE_GLOBAL = 2'd1;
  localparam logic [1:0] MODE_TOURN  = 2'd2;
  localparam logic [1:0] MODE_XOR    = 2'd3;

  // item operation codes
  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_TRAIN   = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic                clear;
    logic [CLR_BITS-1:0] clr_addr;
    logic                load;
    logic                read;
    logic                lookup;
    logic                exec;
  } tbp_cmd_t;

  // saturating step of a 2-bit counter
  function automatic ctr_t ctr_bump(input ctr_t c, input logic taken);
    ctr_t r;
    r = c;
    if (taken) begin
      if (c != CTR_MAX) r = c + 2'd1;
    end else begin
      if (c != CTR_MIN) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/tbp_if.sv =====
// item, result and configuration channels of the branch predictor
interface tbp_item_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] pc;
  logic        outcome;
  logic        is_conditional;
  modport source (output valid, op, pc, outcome, is_conditional, input ready);
  modport sink (input valid, op, pc, outcome, is_conditional, output ready);
endinterface

interface tbp_result_if;
  logic valid;
  logic ready;
  logic prediction;
  modport source (output valid, prediction, input ready);
  modport sink (input valid, prediction, output ready);
endinterface

interface tbp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  modport source (output valid, mode, input ready);
  modport sink (input valid, mode, output ready);
endinterface

// ===== rtl/tournament_branch_predictor_top.sv =====
// Top level of the tournament branch direction predictor (global and local
// components with a per-pc chooser). Every item, predict or train, gives one
// result item. After reset the block runs a clearing pass (one entry of the
// largest table per cycle) and takes no item during it; mode writes are taken
// at any time. An item then goes through these steps in order: accept, read of
// the global, chooser and local history tables, read of the local counter
// addressed by that local history, then update and result, which waits while
// the output register holds an untaken result. The next item is accepted after
// that last step; the two dependent memory reads keep the steps apart. A
// finished result waits in an output register while the next item is accepted.
// The mode register is meant to be written only while idle.
`include "tournament_branch_predictor_top_macros.svh"

module tournament_branch_predictor_top import tbp_pkg::*; (
  input logic          clk,
  input logic          rst,
  tbp_item_if.sink     req,
  tbp_result_if.source rsp,
  tbp_cfg_if.sink      cfg
);

  tbp_cmd_t cmd;
  logic     out_busy;
  logic     out_valid;
  logic     out_pred;

  assign cfg.ready      = 1'b1;
  assign rsp.valid      = out_valid;
  assign rsp.prediction = out_pred;

  // sequencing
  tbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .out_busy  (out_busy),
    .req_ready (req.ready),
    .cmd       (cmd)
  );

  // tables and result
  tbp_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .op             (req.op),
    .pc             (req.pc),
    .outcome        (req.outcome),
    .is_conditional (req.is_conditional),
    .cfg_we         (cfg.valid),
    .cfg_mode       (cfg.mode),
    .out_ready      (rsp.ready),
    .out_valid      (out_valid),
    .out_pred       (out_pred),
    .out_busy       (out_busy)
  );

  // checks
  `TBP_ASSERT_NOW(a_no_accept_in_clear, cmd.clear, !req.ready, "item taken during clear")
  `TBP_ASSERT_NEXT(a_one_item, req.valid && req.ready, !req.ready, "second item too early")
  `TBP_ASSERT_NOW(a_result_from_exec, $rose(rsp.valid), $past(cmd.exec), "stray result item")

endmodule

// ===== rtl/tbp_ram.sv =====
// generic single write port ram with registered read
module tbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // read port, data held until next read
  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/tbp_ctrl.sv =====
// controller: table clearing pass and per-item sequencing
module tbp_ctrl import tbp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     out_busy,
  output logic     req_ready,
  output tbp_cmd_t cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_LOOKUP = 3'd3;
  localparam logic [2:0] S_EXEC   = 3'd4;

  logic [2:0]          state, state_next;
  logic [CLR_BITS-1:0] clr_cnt;

  // next state and commands
  always_comb begin
    state_next   = state;
    req_ready    = 1'b0;
    cmd          = '0;
    cmd.clr_addr = clr_cnt;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (&clr_cnt) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (!out_busy) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // state and clear counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
    end
  end

endmodule

// ===== rtl/tbp_dp.sv =====
// datapath: predictor tables, histories, mode register and result register
module tbp_dp import tbp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  tbp_cmd_t    cmd,
  input  logic        op,
  input  logic [31:0] pc,
  input  logic        outcome,
  input  logic        is_conditional,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_mode,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        out_pred,
  output logic        out_busy
);

  logic [1:0]     mode;
  logic [GHB-1:0] ghist;
  logic           op_r, outcome_r, cond_r;
  logic [31:0]    pc_r;
  logic           last_g, last_l;

  logic [GHB-1:0] g_idx;
  logic [LIB-1:0] lh_idx;
  logic [CIB-1:0] ch_idx;
  ctr_t           g_rd, lc_rd, ch_rd;
  logic [LHB-1:0] lh_rd;
  logic           tourn, train_upd, pred;

  // indices and update conditions
  always_comb begin
    g_idx = ghist;
    if (mode == MODE_XOR) g_idx = ghist ^ pc_r[GHB-1:0];
    lh_idx    = pc_r[LIB-1:0];
    ch_idx    = pc_r[CIB-1:0];
    tourn     = (mode == MODE_TOURN) || (mode == MODE_XOR);
    train_upd = (op_r == OP_TRAIN) && cond_r && (mode != MODE_STATIC);
    out_busy  = out_valid && !out_ready;
  end

  // prediction of the current item
  always_comb begin
    pred = 1'b0;
    if (op_r == OP_PREDICT) begin
      case (mode)
        MODE_STATIC: pred = 1'b1;
        MODE_GLOBAL: pred = g_rd[1];
        default:     pred = ch_rd[1] ? lc_rd[1] : g_rd[1];
      endcase
    end
  end

  // global counters
  tbp_ram #(.WIDTH(2), .DEPTH(1 << GHB)) u_g_ram (
    .clk     (clk),
    .wr_en   (cmd.clear || (cmd.exec && train_upd)),
    .wr_addr (cmd.clear ? cmd.clr_addr[GHB-1:0] : g_idx),
    .wr_data (cmd.clear ? CTR_WEAK_NT : ctr_bump(g_rd, outcome_r)),
    .rd_en   (cmd.read),
    .rd_addr (g_idx),
    .rd_data (g_rd)
  );

  // local histories
  tbp_ram #(.WIDTH(LHB), .DEPTH(1 << LIB)) u_lh_ram (
    .clk     (clk),
    .wr_en   (cmd.clear || (cmd.exec && train_upd && tourn)),
    .wr_addr (cmd.clear ? cmd.clr_addr[LIB-1:0] : lh_idx),
    .wr_data (cmd.clear ? '0 : ((lh_rd << 1) | LHB'(outcome_r))),
    .rd_en   (cmd.read),
    .rd_addr (lh_idx),
    .rd_data (lh_rd)
  );

  // local counters, indexed by the local history read before
  tbp_ram #(.WIDTH(2), .DEPTH(1 << LHB)) u_lc_ram (
    .clk     (clk),
    .wr_en   (cmd.clear || (cmd.exec && train_upd && tourn)),
    .wr_addr (cmd.clear ? cmd.clr_addr[LHB-1:0] : lh_rd),
    .wr_data (cmd.clear ? CTR_STRONG_T : ctr_bump(lc_rd, outcome_r)),
    .rd_en   (cmd.lookup),
    .rd_addr (lh_rd),
    .rd_data (lc_rd)
  );

  // chooser counters, moved only when the latched guesses disagreed
  tbp_ram #(.WIDTH(2), .DEPTH(1 << CIB)) u_ch_ram (
    .clk     (clk),
    .wr_en   (cmd.clear || (cmd.exec && train_upd && tourn && (last_g != last_l))),
    .wr_addr (cmd.clear ? cmd.clr_addr[CIB-1:0] : ch_idx),
    .wr_data (cmd.clear ? CTR_STRONG_T : ctr_bump(ch_rd, outcome_r != last_g)),
    .rd_en   (cmd.read),
    .rd_addr (ch_idx),
    .rd_data (ch_rd)
  );

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= op;
      pc_r      <= pc;
      outcome_r <= outcome;
      cond_r    <= is_conditional;
    end
  end

  // mode, history, latched guesses and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_TOURN;
      ghist     <= '0;
      last_g    <= 1'b0;
      last_l    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) mode <= cfg_mode;
      if (cmd.exec) begin
        out_valid <= 1'b1;
        out_pred  <= pred;
        if (train_upd) ghist <= (ghist << 1) | GHB'(outcome_r);
        if ((op_r == OP_PREDICT) && tourn) begin
          last_g <= g_rd[1];
          last_l <= lc_rd[1];
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
